// File: rtl/b64e_pkg.sv
// b64e_pkg: shared types, constants and the alphabet function of the base64 stream encoder.
// Used by every module under rtl; depends on nothing.
package b64e_pkg;

	localparam logic [6:0] PAD_CHAR = 7'd61;
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] POS_NONE = 2'd0;
	localparam logic [1:0] POS_ONE  = 2'd1;
	localparam logic [1:0] POS_TWO  = 2'd2;

	localparam logic [1:0] SLOT_LAST = 2'd3;

	typedef struct packed {
		logic [3:0][5:0] sext;
		logic [1:0]      npad;
		logic            last;
	} grp_t;

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		if (v < 6'd26) begin
			c = 7'd65 + {1'b0, v};
		end else if (v < 6'd52) begin
			c = 7'd71 + {1'b0, v};
		end else if (v < 6'd62) begin
			c = {1'b0, v} - 7'd4;
		end else if (v == 6'd62) begin
			c = 7'd43;
		end else begin
			c = 7'd47;
		end
		return c;
	endfunction

endpackage

// File: rtl/b64e_front.sv
// b64e_front: accepts message bytes, holds the unfinished group and forms group records.
// Depends on b64e_pkg.
module b64e_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             acc,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	output logic             enq,
	output b64e_pkg::grp_t   grp
);

	logic [1:0] pos_q;
	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic       close;

	always_comb begin
		grp = '0;
		close = 1'b0;
		case (pos_q)
			b64e_pkg::POS_ONE: begin
				close = final_byte;
				grp.sext[0] = pend0_q[7:2];
				grp.sext[1] = {pend0_q[1:0], data_byte[7:4]};
				grp.sext[2] = {data_byte[3:0], 2'b00};
				grp.npad = 2'd1;
				grp.last = 1'b1;
			end
			b64e_pkg::POS_TWO: begin
				close = 1'b1;
				grp.sext[0] = pend0_q[7:2];
				grp.sext[1] = {pend0_q[1:0], pend1_q[7:4]};
				grp.sext[2] = {pend1_q[3:0], data_byte[7:6]};
				grp.sext[3] = data_byte[5:0];
				grp.npad = 2'd0;
				grp.last = final_byte;
			end
			default: begin
				close = final_byte;
				grp.sext[0] = data_byte[7:2];
				grp.sext[1] = {data_byte[1:0], 4'b0000};
				grp.npad = 2'd2;
				grp.last = 1'b1;
			end
		endcase
	end

	assign enq = acc & close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= b64e_pkg::POS_NONE;
		end else if (acc) begin
			if (close) begin
				pos_q <= b64e_pkg::POS_NONE;
			end else if (pos_q == b64e_pkg::POS_ONE) begin
				pos_q <= b64e_pkg::POS_TWO;
			end else begin
				pos_q <= b64e_pkg::POS_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !close) begin
			if (pos_q == b64e_pkg::POS_ONE) begin
				pend1_q <= data_byte;
			end else begin
				pend0_q <= data_byte;
			end
		end
	end

endmodule

// File: rtl/b64e_queue.sv
// b64e_queue: short queue of group records between the front and back parts.
// Depends on b64e_pkg.
module b64e_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             enq,
	input  b64e_pkg::grp_t   enq_grp,
	input  logic             deq,
	output logic             full,
	output logic             empty,
	output b64e_pkg::grp_t   head
);

	b64e_pkg::grp_t                  mem_q [b64e_pkg::QDEPTH];
	logic [b64e_pkg::QPTR_W-1:0]     wr_q;
	logic [b64e_pkg::QPTR_W-1:0]     rd_q;
	logic [b64e_pkg::QCNT_W-1:0]     cnt_q;
	logic                            do_enq;
	logic                            do_deq;

	assign full   = (cnt_q == b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH));
	assign empty  = (cnt_q == '0);
	assign head   = mem_q[rd_q];
	assign do_enq = enq & ~full;
	assign do_deq = deq & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_enq) begin
				wr_q <= (wr_q == b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_deq) begin
				rd_q <= (rd_q == b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_enq && !do_deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_deq && !do_enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_enq) begin
			mem_q[wr_q] <= enq_grp;
		end
	end

endmodule

// File: rtl/b64e_back.sv
// b64e_back: walks the head group record one character per transaction, adds padding.
// Depends on b64e_pkg.
module b64e_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  b64e_pkg::grp_t   head,
	input  logic             pop,
	output logic             deq,
	output logic [6:0]       out_char,
	output logic             out_last
);

	logic [1:0] slot_q;
	logic [2:0] pad_from;
	logic       take;

	assign take     = pop & ~empty;
	assign pad_from = 3'd4 - {1'b0, head.npad};
	assign out_char = ({1'b0, slot_q} >= pad_from) ? b64e_pkg::PAD_CHAR
	                                                 : b64e_pkg::b64_char(head.sext[slot_q]);
	assign out_last = head.last & (slot_q == b64e_pkg::SLOT_LAST);
	assign deq      = take & (slot_q == b64e_pkg::SLOT_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (take) begin
			slot_q <= slot_q + 1'b1;
		end
	end

endmodule

// File: rtl/base64_stream_encoder_top.sv
// Base64 stream encoder (standard alphabet, '=' padding). Bytes enter through a queue-style
// port, one per cycle when full is low; each byte is taken by the front part.
// A byte that closes a group (third byte, or a final byte) places one group record in a
// two-entry queue; the back part then presents that group as four characters, one per pop,
// the fourth character of the final group with out_last set. Sustained rate is set by the
// one-character-per-cycle result port, which gives characters only while empty is low.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
module base64_stream_encoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       empty,
	input  logic       pop,
	output logic [6:0] out_char,
	output logic       out_last
);

	b64e_pkg::grp_t front_grp;
	b64e_pkg::grp_t head_grp;
	logic           acc;
	logic           enq;
	logic           deq;

	assign acc = push & ~full;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.enq        (enq),
		.grp        (front_grp)
	);

	b64e_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.enq     (enq),
		.enq_grp (front_grp),
		.deq     (deq),
		.full    (full),
		.empty   (empty),
		.head    (head_grp)
	);

	b64e_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head_grp),
		.pop      (pop),
		.deq      (deq),
		.out_char (out_char),
		.out_last (out_last)
	);

endmodule
